### rtl/gst_pkg.sv
`timescale 1ns / 1ps

package gst_pkg;

    localparam int LINE_COUNT_BITS = 20;
    localparam int LINE_OUT_BITS   = 20;
    localparam logic [LINE_OUT_BITS-1:0] LINE_OUT_MAX = '1;
    localparam int MAX_RESULTS = 3;

    localparam logic [4:0] TOK_TEXT       = 5'd0;
    localparam logic [4:0] TOK_EOF        = 5'd1;
    localparam logic [4:0] TOK_EQ         = 5'd2;
    localparam logic [4:0] TOK_ARROW      = 5'd3;
    localparam logic [4:0] TOK_DASH_ARROW = 5'd4;
    localparam logic [4:0] TOK_ADD        = 5'd5;
    localparam logic [4:0] TOK_MUL        = 5'd6;
    localparam logic [4:0] TOK_SLASH2     = 5'd7;
    localparam logic [4:0] TOK_SEMI       = 5'd8;
    localparam logic [4:0] TOK_QUERY      = 5'd9;
    localparam logic [4:0] TOK_LPAREN     = 5'd10;
    localparam logic [4:0] TOK_RPAREN     = 5'd11;
    localparam logic [4:0] TOK_SQ_STRING  = 5'd12;
    localparam logic [4:0] TOK_DQ_STRING  = 5'd13;
    localparam logic [4:0] TOK_IDENT      = 5'd14;
    localparam logic [4:0] TOK_ERR        = 5'd15;
    localparam logic [4:0] TOK_KW_BASE    = 5'd16;
    localparam logic [4:0] TOK_ERROR_REP  = 5'd22;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_COMMENT    = 3'd1;
    localparam logic [2:0] ERR_BACKSLASH  = 3'd2;
    localparam logic [2:0] ERR_STRING     = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd4;

    typedef enum logic [10:0] {
        M_IDLE    = 11'b000_0000_0001,
        M_COMMENT = 11'b000_0000_0010,
        M_EQ      = 11'b000_0000_0100,
        M_DASH    = 11'b000_0000_1000,
        M_SLASH   = 11'b000_0001_0000,
        M_BSL     = 11'b000_0010_0000,
        M_SQ      = 11'b000_0100_0000,
        M_SQ_ESC  = 11'b000_1000_0000,
        M_DQ      = 11'b001_0000_0000,
        M_DQ_ESC  = 11'b010_0000_0000,
        M_NAME    = 11'b100_0000_0000
    } mode_t;

    typedef struct packed {
        mode_t                      mode;
        logic [5:0]                 cand;
        logic [3:0]                 len;
        logic [LINE_COUNT_BITS-1:0] line;
        logic                       nl_pending;
    } state_t;

    typedef struct packed {
        logic [4:0] code;
        logic [7:0] text;
        logic [2:0] err;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0]  res;
        logic [1:0]                 count;
        logic [LINE_OUT_BITS-1:0]   line;
    } bundle_t;

endpackage

### rtl/gst_lexer.sv
`timescale 1ns / 1ps

module gst_lexer
(
    input  gst_pkg::state_t  state,
    input  logic             kind,
    input  logic [7:0]       char_code,
    output gst_pkg::state_t  state_next,
    output gst_pkg::bundle_t bundle
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        gst_pkg::mode_t mode;
        logic           tok_en;
        logic [4:0]     code;
        logic [2:0]     err;
        logic           name;
    } idle_t;

    function automatic logic is_name_char(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                          CH_DASH, CH_UNDER, CH_DOT, CH_SLASH, CH_COMMA});
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0, 3'd1: return 4'd7;
            3'd2, 3'd3: return 4'd5;
            3'd4, 3'd5: return 4'd3;
            default:    return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [55:0] word;
        case (k)
            3'd0:    word = "INCLUDE";
            3'd1:    word = "SCANNER";
            3'd2:    word = {"NODES", 16'h0};
            3'd3:    word = {"RULES", 16'h0};
            3'd4:    word = {"EOF", 32'h0};
            3'd5:    word = {"ERR", 32'h0};
            default: word = '0;
        endcase
        case (pos)
            3'd0:    return word[55:48];
            3'd1:    return word[47:40];
            3'd2:    return word[39:32];
            3'd3:    return word[31:24];
            3'd4:    return word[23:16];
            3'd5:    return word[15:8];
            3'd6:    return word[7:0];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [5:0] kw_step(input logic [5:0] cand, input logic [3:0] len,
                                           input logic [7:0] c);
        logic [5:0] r;
        r = cand;
        for (int k = 0; k < 6; k++) begin
            if (len >= kw_len(3'(k)) || kw_char(3'(k), len[2:0]) != c)
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] name_end_code(input logic [5:0] cand, input logic [3:0] len);
        logic [4:0] code;
        code = gst_pkg::TOK_IDENT;
        for (int k = 5; k >= 0; k--) begin
            if (cand[k] && len == kw_len(3'(k)))
            begin
                code = 5'(gst_pkg::TOK_KW_BASE + 5'(k));
            end
        end
        return code;
    endfunction

    function automatic gst_pkg::result_t mk(input logic [4:0] code, input logic [7:0] text,
                                            input logic [2:0] err);
        gst_pkg::result_t r;
        r.code = code;
        r.text = text;
        r.err  = err;
        return r;
    endfunction

    function automatic idle_t idle_class(input logic [7:0] c);
        idle_t r;
        r.mode   = gst_pkg::M_IDLE;
        r.tok_en = 1'b0;
        r.code   = gst_pkg::TOK_TEXT;
        r.err    = gst_pkg::ERR_NONE;
        r.name   = 1'b0;
        case (c)
            CH_SP, CH_TAB, CH_LF: ;
            CH_HASH:  r.mode = gst_pkg::M_COMMENT;
            CH_EQ:    r.mode = gst_pkg::M_EQ;
            CH_DASH:  r.mode = gst_pkg::M_DASH;
            CH_SLASH: r.mode = gst_pkg::M_SLASH;
            CH_BSL:   r.mode = gst_pkg::M_BSL;
            CH_SQ:    r.mode = gst_pkg::M_SQ;
            CH_DQ:    r.mode = gst_pkg::M_DQ;
            CH_PLUS:  begin r.tok_en = 1'b1; r.code = gst_pkg::TOK_ADD;    end
            CH_STAR:  begin r.tok_en = 1'b1; r.code = gst_pkg::TOK_MUL;    end
            CH_SEMI:  begin r.tok_en = 1'b1; r.code = gst_pkg::TOK_SEMI;   end
            CH_QUERY: begin r.tok_en = 1'b1; r.code = gst_pkg::TOK_QUERY;  end
            CH_LPAR:  begin r.tok_en = 1'b1; r.code = gst_pkg::TOK_LPAREN; end
            CH_RPAR:  begin r.tok_en = 1'b1; r.code = gst_pkg::TOK_RPAREN; end
            default:
            begin
                if (is_name_char(c))
                begin
                    r.mode = gst_pkg::M_NAME;
                    r.name = 1'b1;
                end
                else
                begin
                    r.tok_en = 1'b1;
                    r.code   = gst_pkg::TOK_ERROR_REP;
                    r.err    = gst_pkg::ERR_UNEXPECTED;
                end
            end
        endcase
        return r;
    endfunction

    logic [1:0]  n;
    logic        rescan;
    idle_t       idl;
    logic [31:0] line_wide;

    always_comb
    begin
        state_next = state;
        bundle     = '0;
        n          = 2'd0;
        rescan     = 1'b0;
        idl        = idle_class(char_code);

        if (state.nl_pending)
        begin
            if (state.line != '1)
            begin
                state_next.line = state.line + 1'b1;
            end
            state_next.nl_pending = 1'b0;
        end
        if (!kind && char_code == CH_LF)
        begin
            state_next.nl_pending = 1'b1;
        end

        if (kind)
        begin
            case (state.mode)
                gst_pkg::M_COMMENT:
                begin
                    bundle.res[n] = mk(gst_pkg::TOK_ERROR_REP, 8'h00, gst_pkg::ERR_COMMENT);
                    n = n + 2'd1;
                end
                gst_pkg::M_EQ:
                begin
                    bundle.res[n] = mk(gst_pkg::TOK_EQ, 8'h00, gst_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                gst_pkg::M_DASH, gst_pkg::M_SLASH:
                begin
                    bundle.res[n] = mk(gst_pkg::TOK_ERR, 8'h00, gst_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                gst_pkg::M_BSL:
                begin
                    bundle.res[n] = mk(gst_pkg::TOK_ERROR_REP, 8'h00, gst_pkg::ERR_BACKSLASH);
                    n = n + 2'd1;
                end
                gst_pkg::M_SQ, gst_pkg::M_SQ_ESC, gst_pkg::M_DQ, gst_pkg::M_DQ_ESC:
                begin
                    bundle.res[n] = mk(gst_pkg::TOK_ERROR_REP, 8'h00, gst_pkg::ERR_STRING);
                    n = n + 2'd1;
                    bundle.res[n] = mk(gst_pkg::TOK_ERR, 8'h00, gst_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                gst_pkg::M_NAME:
                begin
                    bundle.res[n] = mk(name_end_code(state.cand, state.len), 8'h00,
                                       gst_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                default: ;
            endcase
            bundle.res[n] = mk(gst_pkg::TOK_EOF, 8'h00, gst_pkg::ERR_NONE);
            n = n + 2'd1;
            state_next.mode = gst_pkg::M_IDLE;
            state_next.cand = '1;
            state_next.len  = '0;
        end
        else
        begin
            case (state.mode)
                gst_pkg::M_COMMENT:
                begin
                    if (char_code == CH_LF)
                    begin
                        state_next.mode = gst_pkg::M_IDLE;
                    end
                end
                gst_pkg::M_EQ:
                begin
                    if (char_code == CH_GT)
                    begin
                        bundle.res[n] = mk(gst_pkg::TOK_ARROW, 8'h00, gst_pkg::ERR_NONE);
                        state_next.mode = gst_pkg::M_IDLE;
                    end
                    else
                    begin
                        bundle.res[n] = mk(gst_pkg::TOK_EQ, 8'h00, gst_pkg::ERR_NONE);
                        rescan = 1'b1;
                    end
                    n = n + 2'd1;
                end
                gst_pkg::M_DASH:
                begin
                    if (char_code == CH_GT)
                    begin
                        bundle.res[n] = mk(gst_pkg::TOK_DASH_ARROW, 8'h00, gst_pkg::ERR_NONE);
                        state_next.mode = gst_pkg::M_IDLE;
                    end
                    else
                    begin
                        bundle.res[n] = mk(gst_pkg::TOK_ERR, 8'h00, gst_pkg::ERR_NONE);
                        rescan = 1'b1;
                    end
                    n = n + 2'd1;
                end
                gst_pkg::M_SLASH:
                begin
                    if (char_code == CH_SLASH)
                    begin
                        bundle.res[n] = mk(gst_pkg::TOK_SLASH2, 8'h00, gst_pkg::ERR_NONE);
                        state_next.mode = gst_pkg::M_IDLE;
                    end
                    else
                    begin
                        bundle.res[n] = mk(gst_pkg::TOK_ERR, 8'h00, gst_pkg::ERR_NONE);
                        rescan = 1'b1;
                    end
                    n = n + 2'd1;
                end
                gst_pkg::M_BSL:
                begin
                    if (char_code == CH_LF)
                    begin
                        state_next.mode = gst_pkg::M_IDLE;
                    end
                    else
                    begin
                        bundle.res[n] = mk(gst_pkg::TOK_ERROR_REP, 8'h00,
                                           gst_pkg::ERR_BACKSLASH);
                        n = n + 2'd1;
                        rescan = 1'b1;
                    end
                end
                gst_pkg::M_SQ, gst_pkg::M_DQ:
                begin
                    if (char_code == CH_BSL)
                    begin
                        state_next.mode = (state.mode == gst_pkg::M_SQ) ?
                                          gst_pkg::M_SQ_ESC : gst_pkg::M_DQ_ESC;
                    end
                    else if (char_code == ((state.mode == gst_pkg::M_SQ) ? CH_SQ : CH_DQ))
                    begin
                        bundle.res[n] = mk((state.mode == gst_pkg::M_SQ) ?
                                           gst_pkg::TOK_SQ_STRING : gst_pkg::TOK_DQ_STRING,
                                           8'h00, gst_pkg::ERR_NONE);
                        n = n + 2'd1;
                        state_next.mode = gst_pkg::M_IDLE;
                    end
                    else
                    begin
                        bundle.res[n] = mk(gst_pkg::TOK_TEXT, char_code, gst_pkg::ERR_NONE);
                        n = n + 2'd1;
                    end
                end
                gst_pkg::M_SQ_ESC, gst_pkg::M_DQ_ESC:
                begin
                    bundle.res[n] = mk(gst_pkg::TOK_TEXT, char_code, gst_pkg::ERR_NONE);
                    n = n + 2'd1;
                    state_next.mode = (state.mode == gst_pkg::M_SQ_ESC) ?
                                      gst_pkg::M_SQ : gst_pkg::M_DQ;
                end
                gst_pkg::M_NAME:
                begin
                    if (is_name_char(char_code))
                    begin
                        state_next.cand = kw_step(state.cand, state.len, char_code);
                        if (state.len != 4'd15)
                        begin
                            state_next.len = state.len + 4'd1;
                        end
                        bundle.res[n] = mk(gst_pkg::TOK_TEXT, char_code, gst_pkg::ERR_NONE);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        bundle.res[n] = mk(name_end_code(state.cand, state.len), 8'h00,
                                           gst_pkg::ERR_NONE);
                        n = n + 2'd1;
                        state_next.cand = '1;
                        state_next.len  = '0;
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase

            if (rescan)
            begin
                state_next.mode = idl.mode;
                if (idl.tok_en)
                begin
                    bundle.res[n] = mk(idl.code, 8'h00, idl.err);
                    n = n + 2'd1;
                end
                if (idl.name)
                begin
                    state_next.cand = kw_step('1, 4'd0, char_code);
                    state_next.len  = 4'd1;
                    bundle.res[n] = mk(gst_pkg::TOK_TEXT, char_code, gst_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
            end
        end

        bundle.count = n;
        line_wide    = 32'(state_next.line);
        if (line_wide > 32'(gst_pkg::LINE_OUT_MAX))
        begin
            bundle.line = gst_pkg::LINE_OUT_MAX;
        end
        else
        begin
            bundle.line = line_wide[gst_pkg::LINE_OUT_BITS-1:0];
        end
    end

endmodule

### rtl/gst_emitter.sv
`timescale 1ns / 1ps

module gst_emitter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  gst_pkg::bundle_t                  bundle,
    output logic                              free,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [4:0]                        token_code,
    output logic [7:0]                        text_char,
    output logic [2:0]                        error_code,
    output logic [gst_pkg::LINE_OUT_BITS-1:0] line_number,
    output logic                              last_of_run
);

    gst_pkg::bundle_t bundle_reg;
    logic [1:0]       count_reg;
    logic [1:0]       idx_reg;
    logic [1:0]       count_next;
    logic [1:0]       idx_next;
    logic             last;

    assign out_valid   = (count_reg != 2'd0);
    assign last        = (idx_reg == count_reg - 2'd1);
    assign free        = !out_valid || (!out_stall && last);
    assign token_code  = bundle_reg.res[idx_reg].code;
    assign text_char   = bundle_reg.res[idx_reg].text;
    assign error_code  = bundle_reg.res[idx_reg].err;
    assign line_number = bundle_reg.line;
    assign last_of_run = last;

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            count_next = bundle.count;
            idx_next   = 2'd0;
        end
        else if (out_valid && !out_stall)
        begin
            if (last)
            begin
                count_next = 2'd0;
                idx_next   = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

endmodule

### rtl/grammar_spec_tokenizer.sv
`timescale 1ns / 1ps
// Registers: the input transaction is captured in the input register, its results in the result register.
// Throughput: one character per cycle when each gives at most one result and out_stall is low;
// a character giving more than one result holds the input while the result register drains.
// Reset: asynchronous, active low; mode idle, line counter zero, result register empty.

module grammar_spec_tokenizer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [7:0]                        char_code,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [4:0]                        token_code,
    output logic [7:0]                        text_char,
    output logic [2:0]                        error_code,
    output logic [gst_pkg::LINE_OUT_BITS-1:0] line_number,
    output logic                              last_of_run
);

    logic             in_valid_reg;
    logic             kind_reg;
    logic [7:0]       char_reg;
    gst_pkg::state_t  state_reg;
    gst_pkg::state_t  state_next;
    gst_pkg::bundle_t bundle;
    logic             free;
    logic             process;
    logic             load;

    gst_lexer u_lexer
    (
        .state      (state_reg),
        .kind       (kind_reg),
        .char_code  (char_reg),
        .state_next (state_next),
        .bundle     (bundle)
    );

    gst_emitter u_emitter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .bundle      (bundle),
        .free        (free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_code  (token_code),
        .text_char   (text_char),
        .error_code  (error_code),
        .line_number (line_number),
        .last_of_run (last_of_run)
    );

    assign process  = in_valid_reg && ((bundle.count == 2'd0) || free);
    assign load     = process && (bundle.count != 2'd0);
    assign in_stall = in_valid_reg && !process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            state_reg.mode       <= gst_pkg::M_IDLE;
            state_reg.cand       <= '1;
            state_reg.len        <= '0;
            state_reg.line       <= '0;
            state_reg.nl_pending <= 1'b1;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end
            if (process)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg <= kind;
            char_reg <= char_code;
        end
    end

`ifndef SYNTH
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("result burst broken before its last transaction");

    a_error_pairing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((token_code == gst_pkg::TOK_ERROR_REP) ==
                       (error_code != gst_pkg::ERR_NONE)))
        else $error("error code does not match token code");

    a_text_only_on_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_code != gst_pkg::TOK_TEXT) |-> (text_char == 8'h00))
        else $error("text character on a non-text token");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with result register empty");
`endif

endmodule

### bench/grammar_spec_tokenizer_checker.sv
`timescale 1ns / 1ps

module grammar_spec_tokenizer_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              kind,
    input  logic [7:0]                        char_code,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [4:0]                        token_code,
    input  logic [7:0]                        text_char,
    input  logic [2:0]                        error_code,
    input  logic [gst_pkg::LINE_OUT_BITS-1:0] line_number,
    input  logic                              last_of_run,
    output int                                mismatches,
    output int                                outstanding,
    output int                                checked
);

    import gst_pkg::*;

    typedef struct packed {
        result_t                  tok;
        logic [LINE_OUT_BITS-1:0] line;
        logic                     last;
    } token_rec_t;

    string kw_spelling [6] = '{"INCLUDE", "SCANNER", "NODES", "RULES", "EOF", "ERR"};

    mode_t                      lex_mode;
    logic [5:0]                 kw_live;
    logic [3:0]                 word_len;
    logic [LINE_COUNT_BITS-1:0] line_cnt;
    logic                       line_pend;
    result_t                    step_tokens [$];
    token_rec_t                 expected_tokens [$];

    function automatic bit is_word_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")
            || c == "-" || c == "_" || c == "." || c == "/" || c == ",";
    endfunction

    task automatic add_token(logic [4:0] code, logic [7:0] text, logic [2:0] err);
        result_t r;
        r.code = code;
        r.text = text;
        r.err  = err;
        step_tokens.push_back(r);
    endtask

    task automatic word_char(logic [7:0] c);
        int k;
        for (k = 0; k < 6; k++)
        begin
            if (word_len >= kw_spelling[k].len() || kw_spelling[k][word_len] != c)
                kw_live[k] = 1'b0;
        end
        if (word_len != 4'd15)
            word_len++;
        add_token(TOK_TEXT, c, ERR_NONE);
    endtask

    task automatic word_close();
        int         k;
        logic [4:0] code;
        bit         found;
        code  = TOK_IDENT;
        found = 1'b0;
        for (k = 0; k < 6; k++)
        begin
            if (!found && kw_live[k] && word_len == kw_spelling[k].len())
            begin
                code  = 5'(TOK_KW_BASE + k);
                found = 1'b1;
            end
        end
        add_token(code, 8'h00, ERR_NONE);
        kw_live  = '1;
        word_len = '0;
    endtask

    task automatic fresh_char(logic [7:0] c);
        lex_mode = M_IDLE;
        case (c)
            " ", "\t", "\n": ;
            "#":  lex_mode = M_COMMENT;
            "=":  lex_mode = M_EQ;
            "-":  lex_mode = M_DASH;
            "/":  lex_mode = M_SLASH;
            "\\": lex_mode = M_BSL;
            "'":  lex_mode = M_SQ;
            "\"": lex_mode = M_DQ;
            "+":  add_token(TOK_ADD, 8'h00, ERR_NONE);
            "*":  add_token(TOK_MUL, 8'h00, ERR_NONE);
            ";":  add_token(TOK_SEMI, 8'h00, ERR_NONE);
            "?":  add_token(TOK_QUERY, 8'h00, ERR_NONE);
            "(":  add_token(TOK_LPAREN, 8'h00, ERR_NONE);
            ")":  add_token(TOK_RPAREN, 8'h00, ERR_NONE);
            default:
            begin
                if (is_word_char(c))
                begin
                    kw_live  = '1;
                    word_len = '0;
                    lex_mode = M_NAME;
                    word_char(c);
                end
                else
                    add_token(TOK_ERROR_REP, 8'h00, ERR_UNEXPECTED);
            end
        endcase
    endtask

    task automatic predict_tokens(logic is_end, logic [7:0] c);
        int          i;
        logic [63:0] wide;
        token_rec_t  rec;
        step_tokens.delete();
        if (line_pend)
        begin
            if (line_cnt != '1)
                line_cnt++;
            line_pend = 1'b0;
        end
        if (!is_end && c == "\n")
            line_pend = 1'b1;

        if (is_end)
        begin
            case (lex_mode)
                M_COMMENT:       add_token(TOK_ERROR_REP, 8'h00, ERR_COMMENT);
                M_EQ:            add_token(TOK_EQ, 8'h00, ERR_NONE);
                M_DASH, M_SLASH: add_token(TOK_ERR, 8'h00, ERR_NONE);
                M_BSL:           add_token(TOK_ERROR_REP, 8'h00, ERR_BACKSLASH);
                M_SQ, M_SQ_ESC, M_DQ, M_DQ_ESC:
                begin
                    add_token(TOK_ERROR_REP, 8'h00, ERR_STRING);
                    add_token(TOK_ERR, 8'h00, ERR_NONE);
                end
                M_NAME:          word_close();
                default: ;
            endcase
            add_token(TOK_EOF, 8'h00, ERR_NONE);
            lex_mode = M_IDLE;
            kw_live  = '1;
            word_len = '0;
        end
        else
        begin
            case (lex_mode)
                M_COMMENT:
                begin
                    if (c == "\n")
                        lex_mode = M_IDLE;
                end
                M_EQ:
                begin
                    if (c == ">")
                    begin
                        add_token(TOK_ARROW, 8'h00, ERR_NONE);
                        lex_mode = M_IDLE;
                    end
                    else
                    begin
                        add_token(TOK_EQ, 8'h00, ERR_NONE);
                        fresh_char(c);
                    end
                end
                M_DASH:
                begin
                    if (c == ">")
                    begin
                        add_token(TOK_DASH_ARROW, 8'h00, ERR_NONE);
                        lex_mode = M_IDLE;
                    end
                    else
                    begin
                        add_token(TOK_ERR, 8'h00, ERR_NONE);
                        fresh_char(c);
                    end
                end
                M_SLASH:
                begin
                    if (c == "/")
                    begin
                        add_token(TOK_SLASH2, 8'h00, ERR_NONE);
                        lex_mode = M_IDLE;
                    end
                    else
                    begin
                        add_token(TOK_ERR, 8'h00, ERR_NONE);
                        fresh_char(c);
                    end
                end
                M_BSL:
                begin
                    if (c == "\n")
                        lex_mode = M_IDLE;
                    else
                    begin
                        add_token(TOK_ERROR_REP, 8'h00, ERR_BACKSLASH);
                        fresh_char(c);
                    end
                end
                M_SQ:
                begin
                    if (c == "\\")
                        lex_mode = M_SQ_ESC;
                    else if (c == "'")
                    begin
                        add_token(TOK_SQ_STRING, 8'h00, ERR_NONE);
                        lex_mode = M_IDLE;
                    end
                    else
                        add_token(TOK_TEXT, c, ERR_NONE);
                end
                M_DQ:
                begin
                    if (c == "\\")
                        lex_mode = M_DQ_ESC;
                    else if (c == "\"")
                    begin
                        add_token(TOK_DQ_STRING, 8'h00, ERR_NONE);
                        lex_mode = M_IDLE;
                    end
                    else
                        add_token(TOK_TEXT, c, ERR_NONE);
                end
                M_SQ_ESC:
                begin
                    add_token(TOK_TEXT, c, ERR_NONE);
                    lex_mode = M_SQ;
                end
                M_DQ_ESC:
                begin
                    add_token(TOK_TEXT, c, ERR_NONE);
                    lex_mode = M_DQ;
                end
                M_NAME:
                begin
                    if (is_word_char(c))
                        word_char(c);
                    else
                    begin
                        word_close();
                        fresh_char(c);
                    end
                end
                default: fresh_char(c);
            endcase
        end

        wide = 64'(line_cnt);
        if (wide > 64'(LINE_OUT_MAX))
            wide = 64'(LINE_OUT_MAX);
        for (i = 0; i < step_tokens.size(); i++)
        begin
            rec.tok  = step_tokens[i];
            rec.line = wide[LINE_OUT_BITS-1:0];
            rec.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(rec);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        token_rec_t want;
        if (!rst_n)
        begin
            lex_mode    = M_IDLE;
            kw_live     = '1;
            word_len    = '0;
            line_cnt    = '0;
            line_pend   = 1'b1;
            expected_tokens.delete();
            mismatches  = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_tokens.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected token code %0d text %h err %0d line %0d last %b",
                                 $realtime, token_code, text_char, error_code, line_number,
                                 last_of_run);
                    mismatches++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_code !== want.tok.code || text_char !== want.tok.text
                        || error_code !== want.tok.err || line_number !== want.line
                        || last_of_run !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: token mismatch", $realtime);
                            $display("  expected code %0d text %h err %0d line %0d last %b",
                                     want.tok.code, want.tok.text, want.tok.err, want.line,
                                     want.last);
                            $display("  actual   code %0d text %h err %0d line %0d last %b",
                                     token_code, text_char, error_code, line_number,
                                     last_of_run);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_tokens(kind, char_code);
            outstanding = expected_tokens.size();
        end
    end

endmodule

### bench/grammar_spec_tokenizer_test.sv
`timescale 1ns / 1ps

module grammar_spec_tokenizer_test;

    import gst_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 115;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     kind      = 1'b0;
    logic [7:0]               char_code = 8'h00;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [4:0]               token_code;
    logic [7:0]               text_char;
    logic [2:0]               error_code;
    logic [LINE_OUT_BITS-1:0] line_number;
    logic                     last_of_run;

    int mismatches;
    int outstanding;
    int checked;
    int idle_pct     = 0;
    int stall_pct    = 0;
    bit long_hold    = 1'b0;
    int chars_sent   = 0;
    int marks_sent   = 0;
    int quiet_cycles = 0;

    string kw_word [6] = '{"INCLUDE", "SCANNER", "NODES", "RULES", "EOF", "ERR"};
    string op_word [12] = '{"=", "=>", "->", "//", "-", "/", "+", "*", ";", "?", "(", ")"};
    string word_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.,-/";

    grammar_spec_tokenizer DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_code  (token_code),
        .text_char   (text_char),
        .error_code  (error_code),
        .line_number (line_number),
        .last_of_run (last_of_run)
    );

    grammar_spec_tokenizer_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_code  (token_code),
        .text_char   (text_char),
        .error_code  (error_code),
        .line_number (line_number),
        .last_of_run (last_of_run),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall = long_hold || ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d tokens still expected",
                     quiet_cycles, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] word_pick(bit lead);
        // a name may not start with '-' or '/', which sit at the end of the pool
        return word_pool[lead ? $urandom_range(word_pool.len() - 3)
                              : $urandom_range(word_pool.len() - 1)];
    endfunction

    task automatic send_item(logic is_end, logic [7:0] ch);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid  = 1'b0;
            kind      = 1'($urandom);
            char_code = 8'($urandom);
            @(negedge clk);
        end
        in_valid  = 1'b1;
        kind      = is_end;
        char_code = is_end ? 8'($urandom) : ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (is_end)
            marks_sent++;
        else
            chars_sent++;
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    task automatic send_fragment();
        int         pick;
        int         n;
        int         i;
        string      s;
        logic [7:0] q;
        pick = $urandom_range(99);
        if (pick < 14)
        begin
            // keyword, now and then with one letter changed, the last dropped or one added
            s = kw_word[$urandom_range(5)];
            n = $urandom_range(7);
            for (i = 0; i < s.len() - (n == 1); i++)
                send_item(1'b0, (n == 0 && i == 1) ? word_pick(1'b0) : s[i]);
            if (n == 2)
                send_item(1'b0, word_pick(1'b0));
        end
        else if (pick < 34)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
            send_item(1'b0, word_pick(1'b1));
            for (i = 1; i < n; i++)
                send_item(1'b0, word_pick(1'b0));
        end
        else if (pick < 46)
        begin
            q = $urandom_range(1) ? "'" : "\"";
            send_item(1'b0, q);
            n = $urandom_range(8);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(5) == 0)
                begin
                    send_item(1'b0, "\\");
                    send_item(1'b0, 8'($urandom_range(255)));
                end
                else
                    send_item(1'b0, 8'($urandom_range(3) ? $urandom_range(32, 126)
                                                         : $urandom_range(255)));
            end
            if ($urandom_range(7) != 0)
                send_item(1'b0, q);
        end
        else if (pick < 62)
            send_text(op_word[$urandom_range(11)]);
        else if (pick < 68)
        begin
            send_item(1'b0, "#");
            n = $urandom_range(6);
            for (i = 0; i < n; i++)
                send_item(1'b0, 8'($urandom_range(32, 126)));
            if ($urandom_range(5) != 0)
                send_item(1'b0, "\n");
        end
        else if (pick < 72)
        begin
            send_item(1'b0, "\\");
            send_item(1'b0, $urandom_range(1) ? 8'h0a : 8'($urandom_range(255)));
        end
        else if (pick < 88)
        begin
            case ($urandom_range(2))
                0:       send_item(1'b0, " ");
                1:       send_item(1'b0, "\t");
                default: send_item(1'b0, "\n");
            endcase
        end
        else if (pick < 96)
            send_item(1'b0, 8'($urandom_range(255)));
        else
            send_item(1'b1, 8'h00);
    endtask

    initial
    begin
        int phase;
        int start_count;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 75; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase

            if (phase == 0)
            begin
                send_item(1'b0, 8'h00);
                send_item(1'b0, 8'hff);
                send_text("=>->//+*;?()#c\n\\\n\\x");
                send_item(1'b1, 8'h00);
                // long output hold while input keeps coming, so the block backs up
                fork
                    begin
                        long_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        long_hold = 1'b0;
                    end
                join_none
            end

            start_count = chars_sent + marks_sent;
            while (chars_sent + marks_sent - start_count < RANDOM_PER_PHASE)
                send_fragment();
        end
        send_item(1'b1, 8'h00);

        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Tokenizer run: %0d characters and %0d end marks over four handshake phases",
                 chars_sent, marks_sent);
        $display("with one long output hold; %0d tokens checked, %0d mismatches, %0d left over",
                 checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### grammar_spec_tokenizer.f
rtl/gst_pkg.sv
rtl/gst_lexer.sv
rtl/gst_emitter.sv
rtl/grammar_spec_tokenizer.sv
bench/grammar_spec_tokenizer_checker.sv
bench/grammar_spec_tokenizer_test.sv
